>>> hdl/mapped_multichannel_pwm_assert.svh
// Assertion macros shared by the checker of the mapped multichannel PWM block.
`ifndef MAPPED_MULTICHANNEL_PWM_ASSERT_SVH
`define MAPPED_MULTICHANNEL_PWM_ASSERT_SVH

// Property checked at every clock edge, held off while reset is high.
`define MMPWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define MMPWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mmpwm_pkg.sv
// Types, constants and helper functions of the mapped multichannel PWM block.
package mmpwm_pkg;

  localparam int CHANNELS = 30;
  localparam int DEFAULT_ENTRIES = 30;

  localparam logic [7:0] BASE_ABC = 8'h00;
  localparam logic [7:0] BASE_D   = 8'h02;

  localparam logic [15:0] PERIOD_RESET = 16'd1023;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LEVEL = 2'd1,
    CMD_MAP   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0] port;
    logic [4:0] chan;
    logic [7:0] bits;
  } map_entry_t;

  typedef logic [CHANNELS-1:0][15:0] level_vec_t;
  typedef map_entry_t [CHANNELS-1:0] map_vec_t;

  // Write request from the input stage to the level and map store.
  typedef struct packed {
    logic       level_we;
    logic       map_we;
    logic [4:0] idx;
    logic [15:0] level;
    map_entry_t entry;
  } wr_t;

  // Period counter status seen by the port evaluation.
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] per;
    logic        start;
  } timer_t;

  // One result word.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic       start;
  } result_t;

  localparam logic [1:0] DFLT_PORT [DEFAULT_ENTRIES] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3,
    2'd3, 2'd1, 2'd1, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
  };

  localparam logic [7:0] DFLT_BITS [DEFAULT_ENTRIES] = '{
    8'h04, 8'h02, 8'h01, 8'h20, 8'h10, 8'h08, 8'h80, 8'h80, 8'h40, 8'h10,
    8'h20, 8'h40, 8'h02, 8'h04, 8'h08, 8'h40, 8'h80, 8'h01, 8'h08, 8'h10,
    8'h20, 8'h40, 8'h80, 8'h04, 8'h08, 8'h10, 8'h20, 8'h01, 8'h02, 8'h04
  };

  // Builds a map entry; a channel past the last one falls back to port A
  // and the last channel, keeping the mask.
  function automatic map_entry_t pack_entry(logic [1:0] port, logic [4:0] chan,
                                            logic [7:0] bits);
    map_entry_t e;
    e.port = port;
    e.chan = chan;
    e.bits = bits;
    if (32'(chan) >= CHANNELS) begin
      e.port = 2'd0;
      e.chan = 5'(CHANNELS - 1);
    end
    return e;
  endfunction

  // Reset value of one map entry; entries past the default table are disabled.
  function automatic map_entry_t default_entry(int unsigned i);
    map_entry_t e;
    e = '0;
    if (i < DEFAULT_ENTRIES) begin
      e = pack_entry(DFLT_PORT[i], 5'(i), DFLT_BITS[i]);
    end
    return e;
  endfunction

endpackage

>>> hdl/mapped_multichannel_pwm.sv
// Top level of the mapped multichannel PWM generator.
//
// Input channel (in_valid / in_ready): one word per command. A tick word
// (cmd 0) advances the PWM counter and yields one result word; a level
// write (cmd 1) or a map write (cmd 2) updates the pending copy and yields
// nothing. Writes reach the active copy only on the tick that starts the
// next period. Unused command codes are dropped.
// Output channel (out_valid / out_ready): four port bytes and the period
// start flag for each tick word.
// Configuration: cfg_we / cfg_data write period_max.
// Path: a tick word that is taken enters the input register and is then
// evaluated into the result register once that register is free, and its
// result is shown there until out_ready takes it.
// Throughput: one word per cycle while no tick word waits behind a stalled result,
// set by the single evaluation pass between the two registers.
// Stall: while a result waits, a tick word in the input register holds there
// and drops in_ready until the result is taken; a write word in the input
// register leaves at once, so writes keep flowing while the input register
// holds no tick.
// Reset: the counter clears, period_max returns to 1023, all levels clear,
// both map copies load the default pin map and both registers empty.
module mapped_multichannel_pwm (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [4:0]  entry_index,
  input  logic [15:0] level,
  input  logic [1:0]  map_port,
  input  logic [4:0]  map_channel,
  input  logic [7:0]  map_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  port_a,
  output logic [7:0]  port_b,
  output logic [7:0]  port_c,
  output logic [7:0]  port_d,
  output logic        period_start,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  // Input register.
  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [4:0]  s1_idx;
  logic [15:0] s1_level;
  logic [1:0]  s1_port;
  logic [4:0]  s1_chan;
  logic [7:0]  s1_bits;

  logic                  s1_go;
  logic                  s1_is_tick;
  logic                  idx_ok;
  logic                  tick_fire;
  mmpwm_pkg::wr_t        wr;
  mmpwm_pkg::timer_t     tm;
  mmpwm_pkg::level_vec_t level_eff;
  mmpwm_pkg::map_vec_t   map_eff;
  mmpwm_pkg::result_t    res;

  assign s1_is_tick = (s1_cmd == mmpwm_pkg::CMD_TICK);
  assign idx_ok     = (32'(s1_idx) < mmpwm_pkg::CHANNELS);

  // A tick leaves the input register only when the result register is free;
  // every other word leaves at once, since it makes no result.
  assign s1_go     = s1_valid && (!s1_is_tick || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign tick_fire = s1_go && s1_is_tick;

  // Out-of-range indexes are dropped here, so the store never sees them.
  assign wr.level_we = s1_go && (s1_cmd == mmpwm_pkg::CMD_LEVEL) && idx_ok;
  assign wr.map_we   = s1_go && (s1_cmd == mmpwm_pkg::CMD_MAP) && idx_ok;
  assign wr.idx      = s1_idx;
  assign wr.level    = s1_level;
  assign wr.entry    = mmpwm_pkg::pack_entry(s1_port, s1_chan, s1_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd   <= cmd;
      s1_idx   <= entry_index;
      s1_level <= level;
      s1_port  <= map_port;
      s1_chan  <= map_channel;
      s1_bits  <= map_bits;
    end
  end

  mmpwm_timer u_timer (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .tick     (tick_fire),
    .tm       (tm)
  );

  mmpwm_store u_store (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .tick_start (tick_fire && tm.start),
    .level_eff  (level_eff),
    .map_eff    (map_eff)
  );

  mmpwm_eval u_eval (
    .tm        (tm),
    .level_eff (level_eff),
    .map_eff   (map_eff),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      port_a       <= res.a;
      port_b       <= res.b;
      port_c       <= res.c;
      port_d       <= res.d;
      period_start <= res.start;
    end
  end

endmodule

>>> hdl/mmpwm_store.sv
// Pending and active copies of the channel levels and the pin map.
module mmpwm_store (
  input  logic                  clk,
  input  logic                  rst,
  input  mmpwm_pkg::wr_t        wr,
  input  logic                  tick_start,
  output mmpwm_pkg::level_vec_t level_eff,
  output mmpwm_pkg::map_vec_t   map_eff
);

  mmpwm_pkg::level_vec_t level_pending;
  mmpwm_pkg::level_vec_t level_active;
  mmpwm_pkg::map_vec_t   map_pending;
  mmpwm_pkg::map_vec_t   map_active;
  logic                  swap_pending;
  logic                  swap_now;

  // While no swap is armed the two copies agree, so arming on every
  // in-range write, changed or not, gives the same active copy.
  assign swap_now = tick_start && swap_pending;

  // The swap takes effect on the very tick that starts the period.
  assign level_eff = swap_now ? level_pending : level_active;
  assign map_eff   = swap_now ? map_pending : map_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mmpwm_pkg::CHANNELS; i++) begin
        level_pending[i] <= '0;
        level_active[i]  <= '0;
        map_pending[i]   <= mmpwm_pkg::default_entry(i);
        map_active[i]    <= mmpwm_pkg::default_entry(i);
      end
      swap_pending <= 1'b0;
    end else begin
      if (swap_now) begin
        level_active <= level_pending;
        map_active   <= map_pending;
        swap_pending <= 1'b0;
      end
      if (wr.level_we) begin
        level_pending[wr.idx] <= wr.level;
        swap_pending          <= 1'b1;
      end
      if (wr.map_we) begin
        map_pending[wr.idx] <= wr.entry;
        swap_pending        <= 1'b1;
      end
    end
  end

endmodule

>>> hdl/mmpwm_timer.sv
// Period register and tick counter that wraps at the end of the period.
module mmpwm_timer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                tick,
  output mmpwm_pkg::timer_t   tm
);

  logic [15:0] period_max;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;
  logic [15:0] per;

  assign per = (period_max == 16'd0) ? 16'd1 : period_max;

  // The counter follows the live period, so a shortened period wraps at once.
  always_comb begin
    if (({1'b0, tick_count} + 17'd1) >= {1'b0, per}) begin
      tick_count_next = '0;
    end else begin
      tick_count_next = tick_count + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_max <= mmpwm_pkg::PERIOD_RESET;
      tick_count <= '0;
    end else begin
      if (cfg_we) begin
        period_max <= cfg_data;
      end
      if (tick) begin
        tick_count <= tick_count_next;
      end
    end
  end

  assign tm.count = tick_count;
  assign tm.per   = per;
  assign tm.start = (tick_count == 16'd0);

endmodule

>>> hdl/mmpwm_eval.sv
// Port byte evaluation for one tick from the levels, the map and the counter.
module mmpwm_eval (
  input  mmpwm_pkg::timer_t     tm,
  input  mmpwm_pkg::level_vec_t level_eff,
  input  mmpwm_pkg::map_vec_t   map_eff,
  output mmpwm_pkg::result_t    res
);

  always_comb begin
    logic [mmpwm_pkg::CHANNELS-1:0] on;
    logic [3:0][7:0]                acc;
    // A channel is on below min(level, period); a zero level never is.
    for (int c = 0; c < mmpwm_pkg::CHANNELS; c++) begin
      on[c] = (tm.count < level_eff[c]) && (tm.count < tm.per);
    end
    acc[0] = mmpwm_pkg::BASE_ABC;
    acc[1] = mmpwm_pkg::BASE_ABC;
    acc[2] = mmpwm_pkg::BASE_ABC;
    acc[3] = mmpwm_pkg::BASE_D;
    for (int i = 0; i < mmpwm_pkg::CHANNELS; i++) begin
      if ((map_eff[i].bits != 8'h00) && (32'(map_eff[i].chan) < mmpwm_pkg::CHANNELS)
          && on[map_eff[i].chan]) begin
        acc[map_eff[i].port] = acc[map_eff[i].port] | map_eff[i].bits;
      end
    end
    res.a     = acc[0];
    res.b     = acc[1];
    res.c     = acc[2];
    res.d     = acc[3];
    res.start = tm.start;
  end

endmodule

>>> hdl/mmpwm_checker.sv
// Port-level checker of the mapped multichannel PWM block and its bind.
`include "mapped_multichannel_pwm_assert.svh"

module mmpwm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] port_a,
  input logic [7:0] port_b,
  input logic [7:0] port_c,
  input logic [7:0] port_d,
  input logic       period_start
);

  // A stalled result word holds.
  `MMPWM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(port_a) && $stable(port_b) && $stable(port_c) && $stable(port_d) && $stable(period_start), "stalled result word changed")

  // Port D always carries its fixed bit.
  `MMPWM_ASSERT(a_port_d_base, clk, rst, out_valid |-> port_d[1], "port_d bit 1 is clear")

  // With the result register empty the block always takes a word.
  `MMPWM_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready, "input stalled with no result waiting")

  // Reset empties the result register.
  `MMPWM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result word after reset")

endmodule

bind mapped_multichannel_pwm mmpwm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .port_a       (port_a),
  .port_b       (port_b),
  .port_c       (port_c),
  .port_d       (port_d),
  .period_start (period_start)
);

>>> test/mapped_multichannel_pwm_tb.sv
// Self-checking testbench for the mapped multichannel PWM generator.
`timescale 1ns / 100ps

module mapped_multichannel_pwm_tb;
  import mmpwm_pkg::*;

  // Command code that the block must drop without a result word.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Each side stalls in this many cycles of a hundred, outside the calm stretch.
  localparam int IDLE_PCT = 12;

  // Cycles to let pass after the last result before a period_max write.
  localparam int SETTLE_CYCLES = 4;

  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT = 4000;

  // Words accepted in this range of the input count run with no idling at all.
  localparam int CALM_FIRST = 300;
  localparam int CALM_LAST  = 420;

  // What the driver does with one entry of its plan.
  typedef enum {
    STIM_WORD,   // present one input word
    STIM_CFG,    // write period_max (only ever planned right after a drain)
    STIM_DRAIN   // hold off until every expected result word has come
  } stim_kind_e;

  typedef struct {
    stim_kind_e  kind;
    logic [1:0]  cmd;
    logic [4:0]  idx;
    logic [15:0] level;
    logic [1:0]  port;
    logic [4:0]  chan;
    logic [7:0]  bits;
    logic [15:0] cfg_val;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_TICK;
  logic [4:0]  entry_index = '0;
  logic [15:0] level = '0;
  logic [1:0]  map_port = '0;
  logic [4:0]  map_channel = '0;
  logic [7:0]  map_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  port_a;
  logic [7:0]  port_b;
  logic [7:0]  port_c;
  logic [7:0]  port_d;
  logic        period_start;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  mapped_multichannel_pwm DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .level        (level),
    .map_port     (map_port),
    .map_channel  (map_channel),
    .map_bits     (map_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .port_a       (port_a),
    .port_b       (port_b),
    .port_c       (port_c),
    .port_d       (port_d),
    .period_start (period_start),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // The plan of words, register writes and drains, and the port bytes still owed.
  stim_t   pending_words[$];
  result_t expected_ports[$];

  int mismatches = 0;
  int words_in = 0;
  int settle_left = 0;
  int hang_cycles = 0;
  bit calm;

  assign calm = (words_in >= CALM_FIRST) && (words_in < CALM_LAST);

  // ---------------------------------------------------------------------------
  // Behavioral copy of the generator. It keeps both the pending and the live
  // level and pin map tables, the tick counter and the swap flag, and is
  // stepped once for every word the block accepts.
  // ---------------------------------------------------------------------------
  logic [15:0] lvl_pending [CHANNELS];
  logic [15:0] lvl_live    [CHANNELS];
  map_entry_t  pin_map_pending [CHANNELS];
  map_entry_t  pin_map_live    [CHANNELS];
  logic [15:0] pwm_count;
  logic [15:0] period_reg;
  bit          swap_armed;

  // A map channel past the last one falls back to port A and the last channel;
  // the mask is kept as written.
  function automatic map_entry_t clamp_entry(logic [1:0] port, logic [4:0] chan,
                                             logic [7:0] bits);
    map_entry_t e;
    e.port = port;
    e.chan = chan;
    e.bits = bits;
    if (chan >= CHANNELS) begin
      e.port = 2'd0;
      e.chan = 5'(CHANNELS - 1);
    end
    return e;
  endfunction

  function automatic void pwm_clear();
    period_reg = PERIOD_RESET;
    pwm_count = '0;
    swap_armed = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      lvl_pending[i] = '0;
      lvl_live[i] = '0;
      if (i < DEFAULT_ENTRIES) begin
        pin_map_pending[i] = clamp_entry(DFLT_PORT[i], 5'(i), DFLT_BITS[i]);
      end else begin
        pin_map_pending[i] = '0;
      end
      pin_map_live[i] = pin_map_pending[i];
    end
  endfunction

  // Steps the copy by one accepted word; a tick queues the port bytes it owes.
  function automatic void pwm_apply_word(stim_t w);
    map_entry_t  e;
    result_t     r;
    logic [7:0]  pb [4];
    int unsigned per;
    int unsigned lv;
    bit          first;
    case (w.cmd)
      CMD_LEVEL: begin
        // Only a change arms the swap; writing the same level again does not.
        if (w.idx < CHANNELS && lvl_pending[w.idx] != w.level) begin
          lvl_pending[w.idx] = w.level;
          swap_armed = 1'b1;
        end
      end
      CMD_MAP: begin
        e = clamp_entry(w.port, w.chan, w.bits);
        if (w.idx < CHANNELS && pin_map_pending[w.idx] != e) begin
          pin_map_pending[w.idx] = e;
          swap_armed = 1'b1;
        end
      end
      CMD_TICK: begin
        // A period_max of zero behaves like one.
        per = (period_reg == 0) ? 1 : int'(period_reg);
        first = (pwm_count == 0);
        if (first && swap_armed) begin
          lvl_live = lvl_pending;
          pin_map_live = pin_map_pending;
          swap_armed = 1'b0;
        end
        pb[0] = BASE_ABC;
        pb[1] = BASE_ABC;
        pb[2] = BASE_ABC;
        pb[3] = BASE_D;
        for (int i = 0; i < CHANNELS; i++) begin
          e = pin_map_live[i];
          if (e.bits != 0 && e.chan < CHANNELS) begin
            // Levels above the period clamp to it; a zero level never lights.
            lv = lvl_live[e.chan];
            if (lv > per) lv = per;
            if (lv != 0 && pwm_count < lv) pb[e.port] |= e.bits;
          end
        end
        r.a = pb[0];
        r.b = pb[1];
        r.c = pb[2];
        r.d = pb[3];
        r.start = first;
        expected_ports.push_back(r);
        // The counter follows the live period, so a shortened period wraps
        // right after the current tick.
        if (pwm_count + 1 >= per) pwm_count = '0;
        else pwm_count = pwm_count + 16'd1;
      end
      default: ;  // the unused command is dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Plan building.
  // ---------------------------------------------------------------------------
  function automatic void plan_word(logic [1:0] c, logic [4:0] idx, logic [15:0] lv,
                                    logic [1:0] port, logic [4:0] chan, logic [7:0] bits);
    stim_t s;
    s.kind = STIM_WORD;
    s.cmd = c;
    s.idx = idx;
    s.level = lv;
    s.port = port;
    s.chan = chan;
    s.bits = bits;
    s.cfg_val = '0;
    pending_words.push_back(s);
  endfunction

  function automatic void plan_drain();
    stim_t s;
    s = '{default: '0, kind: STIM_DRAIN};
    pending_words.push_back(s);
  endfunction

  // The register is only ever written with the block idle, so a drain goes first.
  function automatic void plan_period(logic [15:0] v);
    stim_t s;
    plan_drain();
    s = '{default: '0, kind: STIM_CFG};
    s.cfg_val = v;
    pending_words.push_back(s);
  endfunction

  function automatic void plan_ticks(int n);
    for (int i = 0; i < n; i++) plan_word(CMD_TICK, '0, '0, '0, '0, '0);
  endfunction

  // One random word. Most are ticks and well-formed writes; a few are
  // writes to entries past the table or the unused command with random fields.
  function automatic void plan_random_word(int per);
    int pick;
    logic [15:0] lv;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      plan_ticks(1);
    end else if (pick < 78) begin
      // Keep most levels near the period so the on/off edge moves around.
      if ($urandom_range(0, 9) == 0) lv = 16'($urandom_range(0, 65535));
      else lv = 16'($urandom_range(0, per + 3));
      plan_word(CMD_LEVEL, 5'($urandom_range(0, CHANNELS - 1)), lv, '0, '0, '0);
    end else if (pick < 95) begin
      plan_word(CMD_MAP, 5'($urandom_range(0, CHANNELS - 1)), '0,
                2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      plan_word(CMD_UNUSED, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
                2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                8'($urandom_range(0, 255)));
    end else begin
      plan_word(($urandom_range(0, 1) == 0) ? CMD_LEVEL : CMD_MAP,
                5'($urandom_range(CHANNELS, 31)), 16'($urandom_range(0, 65535)),
                2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents planned words on the input channel, performs the
  // register writes and holds off at the drains. The copy is stepped at the
  // edge where a word is accepted.
  // ---------------------------------------------------------------------------
  stim_t cur_word;

  always @(posedge clk) begin : driver
    stim_t s;
    bit    fire;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        pwm_apply_word(cur_word);
        words_in++;
      end
      if (in_valid && !fire) begin
        // The word stays on the bus, unchanged, until the block takes it.
        cfg_we <= 1'b0;
      end else if (settle_left != 0 || pending_words.size() == 0) begin
        if (settle_left != 0) settle_left--;
        in_valid <= 1'b0;
        cfg_we <= 1'b0;
      end else begin
        s = pending_words[0];
        case (s.kind)
          STIM_DRAIN: begin
            in_valid <= 1'b0;
            cfg_we <= 1'b0;
            if (expected_ports.size() == 0) begin
              void'(pending_words.pop_front());
              settle_left = SETTLE_CYCLES;
            end
          end
          STIM_CFG: begin
            in_valid <= 1'b0;
            cfg_we <= 1'b1;
            cfg_data <= s.cfg_val;
            period_reg = s.cfg_val;
            void'(pending_words.pop_front());
          end
          default: begin
            if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
              in_valid <= 1'b0;
            end else begin
              in_valid <= 1'b1;
              cmd <= s.cmd;
              entry_index <= s.idx;
              level <= s.level;
              map_port <= s.port;
              map_channel <= s.chan;
              map_bits <= s.bits;
              cur_word = s;
              void'(pending_words.pop_front());
            end
            cfg_we <= 1'b0;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result words with a randomly stalling ready and checks
  // each one against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ports.size() == 0) begin
          $error("result word with no tick word waiting for it");
          mismatches++;
        end else begin
          want = expected_ports.pop_front();
          check_field("port_a", want.a, port_a);
          check_field("port_b", want.b, port_b);
          check_field("port_c", want.c, port_c);
          check_field("port_d", want.d, port_d);
          check_field("period_start", 8'(want.start), 8'(period_start));
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: a run that accepts nothing on either side for too long is hung.
  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        hang_cycles <= 0;
      end else if (hang_cycles >= HANG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        hang_cycles <= hang_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of the run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int per;
    pwm_clear();

    // Directed part. A tick under the reset setup shows the base pattern with
    // every channel at zero level, then a short period is set.
    plan_ticks(1);
    plan_period(16'd8);
    plan_word(CMD_LEVEL, 5'd5, 16'hFFFF, '0, '0, '0);   // clamps to the period
    plan_word(CMD_LEVEL, 5'd0, 16'd3, '0, '0, '0);
    plan_word(CMD_LEVEL, 5'd12, 16'd1, '0, '0, '0);
    plan_word(CMD_LEVEL, 5'd31, 16'd77, '0, '0, '0);    // index past the table
    plan_word(CMD_MAP, 5'd0, '0, 2'd3, 5'd5, 8'hFF);
    plan_word(CMD_MAP, 5'd29, '0, 2'd2, 5'd31, 8'h81);  // channel out of range
    plan_word(CMD_MAP, 5'd1, '0, 2'd1, 5'd0, 8'h00);    // mask zero disables
    plan_word(CMD_MAP, 5'd31, '0, 2'd3, 5'd0, 8'hFF);   // entry past the table
    plan_word(CMD_UNUSED, 5'd31, 16'hFFFF, 2'd3, 5'd31, 8'hFF);
    // Runs across a period start, where the pending tables take over.
    plan_ticks(10);
    // The counter now sits past the end of the shorter period and must wrap.
    plan_period(16'd3);
    plan_ticks(3);
    plan_period(16'd0);
    plan_ticks(2);
    plan_period(16'hFFFF);
    plan_ticks(1);
    plan_period(16'd1);
    plan_ticks(2);

    // Random part: six settings of the period, each with a hundred words.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1:       per = 1;
        3:       per = 0;
        default: per = $urandom_range(2, 40);
      endcase
      plan_period(16'(per));
      for (int i = 0; i < 100; i++) begin
        // Once, the sender stops mid-phase until every result is in.
        if (ph == 2 && i == 50) plan_drain();
        plan_random_word((per == 0) ? 1 : per);
      end
    end

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_ports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatches == 0 && expected_ports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Reset is held high from time zero and released once.
  initial begin : reset_seq
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
